// ===== hw/rtl/lcg_pkg.sv =====
`default_nettype none
package lcg_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;

	// squared distance, rounded up to an even width
	localparam int SQ_W   = 2 * COORD_BITS + 2;
	// sqrt radicand: squared distance scaled by 2^(2*FRAC_BITS)
	localparam int N_W    = SQ_W + 2 * FRAC_BITS;
	localparam int RT_W   = N_W / 2;
	localparam int REM_W  = RT_W + 2;
	// integer line length
	localparam int LEN_W  = COORD_BITS + 1;
	// gradient, 0 .. 2^FRAC_BITS
	localparam int Q_W    = FRAC_BITS + 1;
	localparam int DREM_W = LEN_W + 1;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [N_W-1:0]   rad;
		logic [RT_W-1:0]  root;
	} sqrt_t;

	typedef struct packed {
		logic [LEN_W-1:0] rem;
		logic [Q_W-1:0]   dvd;
		logic [Q_W-1:0]   quo;
		logic [LEN_W-1:0] divisor;
	} div_t;

	typedef struct packed {
		logic [23:0]     start_color;
		logic [23:0]     end_color;
		logic [SQ_W-1:0] d2;
	} pay_t;

	typedef struct packed {
		logic [23:0] start_color;
		logic [23:0] end_color;
		logic        zero_length;
		logic        beyond_end;
	} blend_pay_t;

	// s + (e - s) * g / 2^FRAC_BITS, truncated
	function automatic logic [7:0] blend(input logic [7:0] s, input logic [7:0] e,
			input logic [Q_W-1:0] g);
		logic signed [8:0]           d;
		logic signed [FRAC_BITS+9:0] acc;
		d   = $signed({1'b0, e}) - $signed({1'b0, s});
		acc = $signed({2'b00, s, {FRAC_BITS{1'b0}}}) + d * $signed({1'b0, g});
		return acc[FRAC_BITS+7:FRAC_BITS];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/line_color_gradient.sv =====
`default_nettype none
// Pipeline from input word to output word: input register, sqrt cell row (one root bit
// per cell), stage-3 register, divider cell row, output register.
// Throughput: one word per cycle; the whole pipe advances when the output register is
// empty or being taken.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module line_color_gradient (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// pixel_x, pixel_y, start_x, start_y, end_x, end_y (12 b each), start_color,
	// end_color (24 b each)
	input  wire  [119:0] s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// pixel_color
	output logic [23:0]  m_tdata,
	// zero_length, beyond_end
	output logic [1:0]   m_tuser
);

	localparam int CB = lcg_pkg::COORD_BITS;

	logic en;

	// input field unpack
	logic signed [CB-1:0] px, py, sx, sy, ex, ey;
	assign px = s_tdata[0*CB +: CB];
	assign py = s_tdata[1*CB +: CB];
	assign sx = s_tdata[2*CB +: CB];
	assign sy = s_tdata[3*CB +: CB];
	assign ex = s_tdata[4*CB +: CB];
	assign ey = s_tdata[5*CB +: CB];

	// ---- stage 1: squared distances ----
	logic signed [CB:0] ddx, ddy, lx, ly;
	logic [CB-1:0]      adx, ady, alx, aly;
	logic [lcg_pkg::SQ_W-1:0] d2_c, len2_c;

	always_comb begin
		ddx = $signed({px[CB-1], px}) - $signed({sx[CB-1], sx});
		ddy = $signed({py[CB-1], py}) - $signed({sy[CB-1], sy});
		lx  = $signed({ex[CB-1], ex}) - $signed({sx[CB-1], sx});
		ly  = $signed({ey[CB-1], ey}) - $signed({sy[CB-1], sy});
		adx = ddx[CB] ? CB'(-ddx) : ddx[CB-1:0];
		ady = ddy[CB] ? CB'(-ddy) : ddy[CB-1:0];
		alx = lx[CB]  ? CB'(-lx)  : lx[CB-1:0];
		aly = ly[CB]  ? CB'(-ly)  : ly[CB-1:0];
		d2_c   = lcg_pkg::SQ_W'(adx * adx) + lcg_pkg::SQ_W'(ady * ady);
		len2_c = lcg_pkg::SQ_W'(alx * alx) + lcg_pkg::SQ_W'(aly * aly);
	end

	logic                     vld_s1;
	logic [lcg_pkg::SQ_W-1:0] len2_s1;
	lcg_pkg::pay_t            pay_s1;

	// ---- sqrt cell row: length and distance lanes, both scaled by 2^(2*FRAC_BITS) ----
	lcg_pkg::sqrt_t len_c  [lcg_pkg::RT_W+1];
	lcg_pkg::sqrt_t dist_c [lcg_pkg::RT_W+1];
	lcg_pkg::pay_t  pay_s2 [lcg_pkg::RT_W];
	logic [lcg_pkg::RT_W-1:0] vld_s2;

	assign len_c[0]  = '{rem: '0, rad: {len2_s1, {(2*lcg_pkg::FRAC_BITS){1'b0}}}, root: '0};
	assign dist_c[0] = '{rem: '0, rad: {pay_s1.d2, {(2*lcg_pkg::FRAC_BITS){1'b0}}},
	                     root: '0};

	for (genvar k = 0; k < lcg_pkg::RT_W; k++) begin : g_sqrt
		lcg_sqrt_cell u_len  (.clk(clk), .en(en), .din(len_c[k]),  .dout(len_c[k+1]));
		lcg_sqrt_cell u_dist (.clk(clk), .en(en), .din(dist_c[k]), .dout(dist_c[k+1]));
	end

	// ---- stage 3: integer length, clamp and zero checks ----
	logic [lcg_pkg::LEN_W-1:0] len_c3;
	logic [lcg_pkg::SQ_W-1:0]  lsq_c3;
	lcg_pkg::pay_t             pay_last2;
	assign pay_last2 = pay_s2[lcg_pkg::RT_W-1];
	// floor(sqrt(len2 * 2^2F)) >> F is floor(sqrt(len2))
	assign len_c3 = len_c[lcg_pkg::RT_W].root[lcg_pkg::RT_W-1:lcg_pkg::FRAC_BITS];
	assign lsq_c3 = lcg_pkg::SQ_W'(len_c3 * len_c3);

	logic                      vld_s3;
	logic [lcg_pkg::LEN_W-1:0] len_s3;
	logic [lcg_pkg::RT_W-1:0]  rd_s3;
	lcg_pkg::blend_pay_t       pay_s3;

	// ---- divider cell row: g = floor(sqrt(d2 * 2^2F) / len) ----
	lcg_pkg::div_t        div_c [lcg_pkg::Q_W+1];
	lcg_pkg::blend_pay_t  pay_s4 [lcg_pkg::Q_W];
	logic [lcg_pkg::Q_W-1:0] vld_s4;

	// quotient fits Q_W bits when unclamped, so the top bits start below len
	assign div_c[0] = '{rem: {1'b0, rd_s3[lcg_pkg::RT_W-1:lcg_pkg::Q_W]},
	                    dvd: rd_s3[lcg_pkg::Q_W-1:0], quo: '0, divisor: len_s3};

	for (genvar k = 0; k < lcg_pkg::Q_W; k++) begin : g_div
		lcg_div_cell u_div (.clk(clk), .en(en), .din(div_c[k]), .dout(div_c[k+1]));
	end

	// ---- stage 5: channel blend into the output register ----
	lcg_pkg::blend_pay_t    pay_last4;
	logic [lcg_pkg::Q_W-1:0] grad;
	logic [23:0]             color_c5;
	assign pay_last4 = pay_s4[lcg_pkg::Q_W-1];
	assign grad = pay_last4.beyond_end ? lcg_pkg::Q_W'(1 << lcg_pkg::FRAC_BITS)
	                                   : div_c[lcg_pkg::Q_W].quo;

	always_comb begin
		if (pay_last4.zero_length) begin
			color_c5 = pay_last4.start_color;
		end else begin
			for (int c = 0; c < 3; c++) begin
				color_c5[c*8 +: 8] = lcg_pkg::blend(pay_last4.start_color[c*8 +: 8],
				                                    pay_last4.end_color[c*8 +: 8], grad);
			end
		end
	end

	logic        vld_s5;
	logic [23:0] color_s5;
	logic        zero_s5;
	logic        beyond_s5;

	// whole pipe moves together; stalls only when the output word is held
	assign en       = !vld_s5 || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s5;
	assign m_tdata  = color_s5;
	assign m_tuser  = {beyond_s5, zero_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= '0;
			vld_s3 <= 1'b0;
			vld_s4 <= '0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= {vld_s2[lcg_pkg::RT_W-2:0], vld_s1};
			vld_s3 <= vld_s2[lcg_pkg::RT_W-1];
			vld_s4 <= {vld_s4[lcg_pkg::Q_W-2:0], vld_s3};
			vld_s5 <= vld_s4[lcg_pkg::Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s1            <= len2_c;
			pay_s1.d2          <= d2_c;
			pay_s1.start_color <= s_tdata[6*CB +: 24];
			pay_s1.end_color   <= s_tdata[6*CB+24 +: 24];

			pay_s2[0] <= pay_s1;
			for (int k = 1; k < lcg_pkg::RT_W; k++) begin
				pay_s2[k] <= pay_s2[k-1];
			end

			len_s3             <= len_c3;
			rd_s3              <= dist_c[lcg_pkg::RT_W].root;
			pay_s3.start_color <= pay_last2.start_color;
			pay_s3.end_color   <= pay_last2.end_color;
			pay_s3.zero_length <= (len_c3 == '0);
			pay_s3.beyond_end  <= (len_c3 != '0) && (pay_last2.d2 > lsq_c3);

			pay_s4[0] <= pay_s3;
			for (int k = 1; k < lcg_pkg::Q_W; k++) begin
				pay_s4[k] <= pay_s4[k-1];
			end

			color_s5  <= color_c5;
			zero_s5   <= pay_last4.zero_length;
			beyond_s5 <= pay_last4.beyond_end;
		end
	end

`ifndef ASSERT_OFF
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not track output register");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("zero_length and beyond_end both set");
	a_zero_len_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && pay_s3.zero_length) |-> (len_s3 == '0 && !pay_s3.beyond_end))
		else $error("zero-length flag inconsistent");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/lcg_sqrt_cell.sv =====
`default_nettype none
module lcg_sqrt_cell (
	input  wire              clk,
	input  wire              en,
	input  lcg_pkg::sqrt_t   din,
	output lcg_pkg::sqrt_t   dout
);

	logic [lcg_pkg::REM_W-1:0] rem2;
	logic [lcg_pkg::REM_W-1:0] trial;
	logic                      take;
	lcg_pkg::sqrt_t            nxt;
	lcg_pkg::sqrt_t            cell_q;

	// one root bit: bring down two radicand bits, try root*4+1
	always_comb begin
		rem2  = {din.rem[lcg_pkg::REM_W-3:0], din.rad[lcg_pkg::N_W-1 -: 2]};
		trial = {din.root, 2'b01};
		take  = (rem2 >= trial);
		nxt.rad  = {din.rad[lcg_pkg::N_W-3:0], 2'b00};
		nxt.rem  = take ? (rem2 - trial) : rem2;
		nxt.root = {din.root[lcg_pkg::RT_W-2:0], take};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lcg_div_cell.sv =====
`default_nettype none
module lcg_div_cell (
	input  wire             clk,
	input  wire             en,
	input  lcg_pkg::div_t   din,
	output lcg_pkg::div_t   dout
);

	logic [lcg_pkg::DREM_W-1:0] rem2;
	logic                       take;
	lcg_pkg::div_t              nxt;
	lcg_pkg::div_t              cell_q;

	// one quotient bit of restoring division
	always_comb begin
		rem2 = {din.rem, din.dvd[lcg_pkg::Q_W-1]};
		take = (rem2 >= {1'b0, din.divisor});
		nxt.divisor = din.divisor;
		nxt.dvd     = {din.dvd[lcg_pkg::Q_W-2:0], 1'b0};
		nxt.rem     = take ? lcg_pkg::LEN_W'(rem2 - {1'b0, din.divisor})
		                   : rem2[lcg_pkg::LEN_W-1:0];
		nxt.quo     = {din.quo[lcg_pkg::Q_W-2:0], take};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule
`default_nettype wire
